// ===== hdl/fbpa_pkg.sv =====
// Shared types, constants and helpers of the fixed-size block pool allocator.
package fbpa_pkg;

  localparam int FREE_DEPTH   = 1024;
  localparam int HEADER_BYTES = 8;

  localparam int ADDR_W   = 32;
  localparam int PAGE_W   = 21;
  localparam int BLOCK_W  = 17;
  localparam int ALIGN_W  = 4;
  localparam int LIMIT_W  = 16;
  localparam int TOTAL_W  = 48;
  localparam int STRIDE_W = BLOCK_W + 1;
  localparam int LOST_W   = PAGE_W;
  localparam int FADDR_W  = $clog2(FREE_DEPTH);
  localparam int FCNT_W   = $clog2(FREE_DEPTH + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ALIGN_W-1:0] ALIGN_MIN = ALIGN_W'(3);
  localparam logic [ALIGN_W-1:0] ALIGN_MAX = ALIGN_W'(12);

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEMORY = 2'd1,
    ST_STACK_FULL = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT  = 3'd4;

  localparam logic [ADDR_W-1:0]  RST_ARENA_BASE  = '0;
  localparam logic [PAGE_W-1:0]  RST_PAGE_BYTES  = PAGE_W'(4096);
  localparam logic [BLOCK_W-1:0] RST_BLOCK_BYTES = BLOCK_W'(64);
  localparam logic [ALIGN_W-1:0] RST_ALIGN_LOG2  = ALIGN_W'(3);
  localparam logic [LIMIT_W-1:0] RST_PAGE_LIMIT  = LIMIT_W'(256);

  // Block size raised to the header size, rounded up to the clamped alignment.
  function automatic logic [STRIDE_W-1:0] stride_calc(input logic [BLOCK_W-1:0] block_bytes,
                                                      input logic [ALIGN_W-1:0] align_log2);
    logic [ALIGN_W-1:0]  lg;
    logic [STRIDE_W-1:0] size;
    logic [STRIDE_W-1:0] amask;
    lg = (align_log2 < ALIGN_MIN) ? ALIGN_MIN :
         ((align_log2 > ALIGN_MAX) ? ALIGN_MAX : align_log2);
    size = (block_bytes < BLOCK_W'(HEADER_BYTES)) ? STRIDE_W'(HEADER_BYTES)
                                                  : {1'b0, block_bytes};
    amask = (STRIDE_W'(1) << lg) - STRIDE_W'(1);
    return (size + amask) & ~amask;
  endfunction

endpackage

// ===== hdl/fbpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/fbpa_mod.sv =====
// Bit-serial restoring remainder unit: page size modulo stride, one bit per cycle.
module fbpa_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [fbpa_pkg::PAGE_W-1:0]   dividend,
  input  logic [fbpa_pkg::STRIDE_W-1:0] divisor,
  output logic                          done,
  output logic [fbpa_pkg::STRIDE_W-1:0] remainder
);

  localparam int IDX_W = $clog2(fbpa_pkg::PAGE_W);

  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [fbpa_pkg::STRIDE_W-1:0] rem_r, rem_nxt;
  logic [fbpa_pkg::STRIDE_W:0]   trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    idx_nxt  = idx_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dividend[idx_r]};
    if (go) begin
      run_nxt = 1'b1;
      idx_nxt = IDX_W'(fbpa_pkg::PAGE_W - 1);
      rem_nxt = '0;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt = trial[fbpa_pkg::STRIDE_W-1:0];
      if (idx_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    idx_r <= idx_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/fixed_block_pool_allocator_top.sv =====
// Top level of the fixed-size block pool allocator.
//
// A request is taken when start is high and busy is low. An allocation served from
// the freed stack or from the current page, a free, a flush or an unused code keeps
// busy high only in S_EXEC; the result is strobed on out_valid in the next cycle,
// during which the next start is already taken. An allocation that opens a new
// page also passes through the page-base multiply and page set-up states. Opening
// the first page of a pool also runs the bit-serial remainder unit over the 21
// page-size bits between those two states. Results cannot be held off: each is
// shown for exactly one cycle. The freed stack lives in a RAM with a registered
// read port; it needs no clearing after reset.
module fixed_block_pool_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [fbpa_pkg::ADDR_W-1:0]    in_free_address,
  output logic                           out_valid,
  output logic [fbpa_pkg::ADDR_W-1:0]    out_block_address,
  output logic [1:0]                     out_status,
  output logic [fbpa_pkg::TOTAL_W-1:0]   out_bytes_allocated,
  output logic [fbpa_pkg::TOTAL_W-1:0]   out_bytes_used,
  output logic [fbpa_pkg::TOTAL_W-1:0]   out_bytes_lost,
  input  logic                           cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_PAGE = 5'b10000
  } state_t;

  localparam int PROD_W = fbpa_pkg::LIMIT_W + fbpa_pkg::PAGE_W;

  // configuration
  logic [fbpa_pkg::ADDR_W-1:0]  arena_base_r;
  logic [fbpa_pkg::PAGE_W-1:0]  page_bytes_r;
  logic [fbpa_pkg::BLOCK_W-1:0] block_bytes_r;
  logic [fbpa_pkg::ALIGN_W-1:0] align_log2_r;
  logic [fbpa_pkg::LIMIT_W-1:0] page_limit_r;

  state_t                        state_r, state_nxt;
  fbpa_pkg::req_t                req_r, req_nxt;
  logic [fbpa_pkg::ADDR_W-1:0]   faddr_r, faddr_nxt;
  logic [fbpa_pkg::FCNT_W-1:0]   fcount_r, fcount_nxt;
  logic [fbpa_pkg::ADDR_W-1:0]   page_base_r, page_base_nxt;
  logic [fbpa_pkg::PAGE_W-1:0]   page_off_r, page_off_nxt;
  logic [fbpa_pkg::LIMIT_W-1:0]  pages_r, pages_nxt;
  logic [fbpa_pkg::STRIDE_W-1:0] stride_r, stride_nxt;
  logic [fbpa_pkg::LOST_W-1:0]   lost_pp_r, lost_pp_nxt;
  logic [fbpa_pkg::TOTAL_W-1:0]  alloc_tot_r, alloc_tot_nxt;
  logic [fbpa_pkg::TOTAL_W-1:0]  used_tot_r, used_tot_nxt;
  logic [fbpa_pkg::TOTAL_W-1:0]  lost_tot_r, lost_tot_nxt;
  logic [fbpa_pkg::ADDR_W-1:0]   prod_r, prod_nxt;
  logic                          ov_r, ov_nxt;
  logic [fbpa_pkg::ADDR_W-1:0]   oaddr_r, oaddr_nxt;
  fbpa_pkg::status_t             ostat_r, ostat_nxt;

  logic [PROD_W-1:0]             prod_full;
  logic [fbpa_pkg::PAGE_W:0]     fit_sum;
  logic                          need_page;
  logic                          no_page;
  logic [fbpa_pkg::ADDR_W-1:0]   new_base;
  logic                          ram_we;
  logic [fbpa_pkg::FADDR_W-1:0]  ram_raddr;
  logic [fbpa_pkg::FCNT_W-1:0]   pop_idx;
  logic [fbpa_pkg::ADDR_W-1:0]   ram_rdata;
  logic                          mod_go;
  logic                          mod_done;
  logic [fbpa_pkg::STRIDE_W-1:0] mod_rem;
  logic                          accept;

  fbpa_ram #(
    .WIDTH(fbpa_pkg::ADDR_W),
    .DEPTH(fbpa_pkg::FREE_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fcount_r[fbpa_pkg::FADDR_W-1:0]),
    .wdata(faddr_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  fbpa_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (page_bytes_r),
    .divisor  (stride_r),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  assign accept    = start && (state_r == S_IDLE);
  assign pop_idx   = fcount_r - fbpa_pkg::FCNT_W'(1);
  assign ram_raddr = pop_idx[fbpa_pkg::FADDR_W-1:0];
  assign prod_full = {{fbpa_pkg::PAGE_W{1'b0}}, pages_r} *
                     {{fbpa_pkg::LIMIT_W{1'b0}}, page_bytes_r};
  assign fit_sum   = {1'b0, page_off_r} + (fbpa_pkg::PAGE_W + 1)'(stride_r);
  assign need_page = (pages_r == '0) || (fit_sum > {1'b0, page_bytes_r});
  assign no_page   = (pages_r >= page_limit_r) ||
                     ({2'b00, page_bytes_r} < (fbpa_pkg::PAGE_W + 2)'({stride_r, 1'b0}));
  assign new_base  = arena_base_r + prod_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    faddr_nxt     = faddr_r;
    fcount_nxt    = fcount_r;
    page_base_nxt = page_base_r;
    page_off_nxt  = page_off_r;
    pages_nxt     = pages_r;
    stride_nxt    = stride_r;
    lost_pp_nxt   = lost_pp_r;
    alloc_tot_nxt = alloc_tot_r;
    used_tot_nxt  = used_tot_r;
    lost_tot_nxt  = lost_tot_r;
    prod_nxt      = prod_r;
    ov_nxt        = 1'b0;
    oaddr_nxt     = oaddr_r;
    ostat_nxt     = ostat_r;
    ram_we        = 1'b0;
    mod_go        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = fbpa_pkg::req_t'(in_req_type);
          faddr_nxt = in_free_address;
          // geometry follows the registers until the first page is taken
          if (pages_r == '0 && (in_req_type == fbpa_pkg::REQ_ALLOC ||
                                in_req_type == fbpa_pkg::REQ_FREE)) begin
            stride_nxt = fbpa_pkg::stride_calc(block_bytes_r, align_log2_r);
          end
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        oaddr_nxt = '0;
        ostat_nxt = fbpa_pkg::ST_OK;
        case (req_r)
          fbpa_pkg::REQ_ALLOC: begin
            if (fcount_r != '0) begin
              fcount_nxt   = pop_idx;
              oaddr_nxt    = ram_rdata;
              used_tot_nxt = used_tot_r + fbpa_pkg::TOTAL_W'(stride_r);
            end else if (!need_page) begin
              oaddr_nxt    = page_base_r + fbpa_pkg::ADDR_W'(page_off_r);
              page_off_nxt = fit_sum[fbpa_pkg::PAGE_W-1:0];
              used_tot_nxt = used_tot_r + fbpa_pkg::TOTAL_W'(stride_r);
            end else if (no_page) begin
              ostat_nxt = fbpa_pkg::ST_NO_MEMORY;
            end else begin
              ov_nxt    = 1'b0;
              state_nxt = S_MUL;
            end
          end
          fbpa_pkg::REQ_FREE: begin
            if (fcount_r == fbpa_pkg::FCNT_W'(fbpa_pkg::FREE_DEPTH)) begin
              ostat_nxt = fbpa_pkg::ST_STACK_FULL;
            end else begin
              ram_we       = 1'b1;
              fcount_nxt   = fcount_r + fbpa_pkg::FCNT_W'(1);
              used_tot_nxt = (used_tot_r >= fbpa_pkg::TOTAL_W'(stride_r)) ?
                             used_tot_r - fbpa_pkg::TOTAL_W'(stride_r) : '0;
            end
          end
          fbpa_pkg::REQ_FLUSH: begin
            fcount_nxt    = '0;
            page_base_nxt = '0;
            page_off_nxt  = '0;
            pages_nxt     = '0;
            stride_nxt    = '0;
            lost_pp_nxt   = '0;
            alloc_tot_nxt = '0;
            used_tot_nxt  = '0;
            lost_tot_nxt  = '0;
          end
          default: begin
          end
        endcase
      end
      S_MUL: begin
        prod_nxt = prod_full[fbpa_pkg::ADDR_W-1:0];
        if (pages_r == '0) begin
          mod_go    = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_PAGE;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          lost_pp_nxt = fbpa_pkg::LOST_W'(mod_rem) + fbpa_pkg::LOST_W'(stride_r);
          state_nxt   = S_PAGE;
        end
      end
      S_PAGE: begin
        // first stride of the page is the header; hand out the second
        page_base_nxt = new_base;
        pages_nxt     = pages_r + fbpa_pkg::LIMIT_W'(1);
        page_off_nxt  = fbpa_pkg::PAGE_W'({stride_r, 1'b0});
        alloc_tot_nxt = alloc_tot_r + fbpa_pkg::TOTAL_W'(page_bytes_r);
        lost_tot_nxt  = lost_tot_r + fbpa_pkg::TOTAL_W'(lost_pp_r);
        used_tot_nxt  = used_tot_r + fbpa_pkg::TOTAL_W'(stride_r);
        ov_nxt        = 1'b1;
        oaddr_nxt     = new_base + fbpa_pkg::ADDR_W'(stride_r);
        ostat_nxt     = fbpa_pkg::ST_OK;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_base_r  <= fbpa_pkg::RST_ARENA_BASE;
      page_bytes_r  <= fbpa_pkg::RST_PAGE_BYTES;
      block_bytes_r <= fbpa_pkg::RST_BLOCK_BYTES;
      align_log2_r  <= fbpa_pkg::RST_ALIGN_LOG2;
      page_limit_r  <= fbpa_pkg::RST_PAGE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        fbpa_pkg::CFG_ARENA_BASE:  arena_base_r  <= cfg_wdata[fbpa_pkg::ADDR_W-1:0];
        fbpa_pkg::CFG_PAGE_BYTES:  page_bytes_r  <= cfg_wdata[fbpa_pkg::PAGE_W-1:0];
        fbpa_pkg::CFG_BLOCK_BYTES: block_bytes_r <= cfg_wdata[fbpa_pkg::BLOCK_W-1:0];
        fbpa_pkg::CFG_ALIGN_LOG2:  align_log2_r  <= cfg_wdata[fbpa_pkg::ALIGN_W-1:0];
        fbpa_pkg::CFG_PAGE_LIMIT:  page_limit_r  <= cfg_wdata[fbpa_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fcount_r    <= '0;
      page_base_r <= '0;
      page_off_r  <= '0;
      pages_r     <= '0;
      stride_r    <= '0;
      lost_pp_r   <= '0;
      alloc_tot_r <= '0;
      used_tot_r  <= '0;
      lost_tot_r  <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fcount_r    <= fcount_nxt;
      page_base_r <= page_base_nxt;
      page_off_r  <= page_off_nxt;
      pages_r     <= pages_nxt;
      stride_r    <= stride_nxt;
      lost_pp_r   <= lost_pp_nxt;
      alloc_tot_r <= alloc_tot_nxt;
      used_tot_r  <= used_tot_nxt;
      lost_tot_r  <= lost_tot_nxt;
      ov_r        <= ov_nxt;
    end
    req_r   <= req_nxt;
    faddr_r <= faddr_nxt;
    prod_r  <= prod_nxt;
    oaddr_r <= oaddr_nxt;
    ostat_r <= ostat_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = ov_r;
  assign out_block_address   = oaddr_r;
  assign out_status          = ostat_r;
  assign out_bytes_allocated = alloc_tot_r;
  assign out_bytes_used      = used_tot_r;
  assign out_bytes_lost      = lost_tot_r;

endmodule

// ===== hdl/fbpa_checker.sv =====
// Port-level assertions for the allocator top level, bound to it.
module fbpa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [fbpa_pkg::ADDR_W-1:0] out_block_address,
  input logic [1:0]                  out_status
);

  // a taken item always raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // results are strobed only once the block has gone idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // one item never yields two results back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // failed items carry a zero address, as do non-allocating ones, though only errors are checked
  a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fbpa_pkg::ST_NO_MEMORY ||
                  out_status == fbpa_pkg::ST_STACK_FULL) |-> out_block_address == '0)
    else $error("error result with nonzero address");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_block_address(out_block_address),
  .out_status       (out_status)
);
